@@ sv/touch_spike_reject_filter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the touch spike reject filter
// ----------------------------------------------------------------------------
`ifndef TOUCH_SPIKE_REJECT_FILTER_UNIT_ASSERT_SVH
`define TOUCH_SPIKE_REJECT_FILTER_UNIT_ASSERT_SVH

// clocked check, off while reset is active
`define TSRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check, also live during reset
`define TSRF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/tsrf_pkg.sv @@
// ----------------------------------------------------------------------------
// tsrf_pkg
// Types and constants shared by the touch spike reject filter.
// ----------------------------------------------------------------------------
package tsrf_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned PressW   = 16;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned LimSqW   = 2 * LimitW;
  localparam int unsigned DistW    = 2 * CoordW + 2;
  localparam int unsigned DataW    = 2 * CoordW + PressW;
  localparam int unsigned QDepth   = 3;
  localparam int unsigned QIdxW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [LimitW-1:0] LimitReset = 16'd30;
  localparam logic [LimSqW-1:0] LimSqReset = LimSqW'(LimitReset * LimitReset);

  // packed so that x sits in the lowest bits
  typedef struct packed {
    logic        [PressW-1:0] p;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } sample_t;

  typedef struct packed {
    sample_t s;
    logic    last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } res_t;

  function automatic logic [DistW-1:0] sq_dist(sample_t a, sample_t b);
    logic signed [CoordW:0]     dx;
    logic signed [CoordW:0]     dy;
    logic signed [2*CoordW+1:0] px;
    logic signed [2*CoordW+1:0] py;
    dx = (CoordW+1)'(a.x) - (CoordW+1)'(b.x);
    dy = (CoordW+1)'(a.y) - (CoordW+1)'(b.y);
    px = dx * dx;
    py = dy * dy;
    return DistW'($unsigned(px)) + DistW'($unsigned(py));
  endfunction

endpackage

@@ sv/tsrf_core.sv @@
// ----------------------------------------------------------------------------
// tsrf_core
// Held/suspect state, distance checks and result selection for one sample.
// ----------------------------------------------------------------------------
module tsrf_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tsrf_pkg::LimitW-1:0] cfg_data_i,
  input  logic                      fire_i,
  input  tsrf_pkg::sample_t         smp_i,
  output tsrf_pkg::res_t            res_o
);
  import tsrf_pkg::*;

  logic [LimSqW-1:0] lim_sq_q;
  sample_t           held_q, held_d;
  sample_t           susp_q, susp_d;
  logic              held_vld_q, held_vld_d;
  logic              susp_vld_q, susp_vld_d;
  logic              jump_h, jump_s;

  assign jump_h = sq_dist(smp_i, held_q) > DistW'(lim_sq_q);
  assign jump_s = sq_dist(smp_i, susp_q) > DistW'(lim_sq_q);

  always_comb begin
    res_o      = '0;
    held_d     = held_q;
    susp_d     = susp_q;
    held_vld_d = held_vld_q;
    susp_vld_d = susp_vld_q;
    if (smp_i.p == '0) begin
      res_o.n    = 2'd1;
      res_o.r0   = '{s: smp_i, last: 1'b1};
      held_d     = smp_i;
      held_vld_d = 1'b0;
      susp_vld_d = 1'b0;
    end else if (!held_vld_q) begin
      res_o.n    = 2'd1;
      res_o.r0   = '{s: smp_i, last: 1'b1};
      held_d     = smp_i;
      held_vld_d = 1'b1;
    end else if (jump_h) begin
      susp_d = smp_i;
      if (susp_vld_q) begin
        held_d = susp_q;
        if (jump_s) begin
          res_o.n    = 2'd1;
          res_o.r0   = '{s: susp_q, last: 1'b1};
          susp_vld_d = 1'b1;
        end else begin
          // suspect goes out twice, then the sample is held
          res_o.n    = 2'd2;
          res_o.r0   = '{s: susp_q, last: 1'b0};
          res_o.r1   = '{s: susp_q, last: 1'b1};
          susp_vld_d = 1'b0;
          held_d     = smp_i;
        end
      end else begin
        susp_vld_d = 1'b1;
      end
    end else begin
      res_o.n    = 2'd1;
      res_o.r0   = '{s: held_q, last: 1'b1};
      held_d     = smp_i;
      susp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_sq_q   <= LimSqReset;
      held_q     <= '0;
      susp_q     <= '0;
      held_vld_q <= 1'b0;
      susp_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_sq_q <= LimSqW'(cfg_data_i) * LimSqW'(cfg_data_i);
      end
      if (fire_i) begin
        held_q     <= held_d;
        susp_q     <= susp_d;
        held_vld_q <= held_vld_d;
        susp_vld_q <= susp_vld_d;
      end
    end
  end

endmodule

@@ sv/tsrf_outq.sv @@
// ----------------------------------------------------------------------------
// tsrf_outq
// Small result queue; takes up to two results per cycle, gives one per cycle while rdy_i is high.
// ----------------------------------------------------------------------------
module tsrf_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tsrf_pkg::res_t      res_i,
  output logic                room_o,
  output logic                vld_o,
  input  logic                rdy_i,
  output tsrf_pkg::out_item_t head_o
);
  import tsrf_pkg::*;

  out_item_t         slot_q [QDepth];
  out_item_t         slot_d [QDepth];
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              pop;

  assign vld_o  = cnt_q != '0;
  assign room_o = cnt_q <= QCntW'(QDepth - 2);
  assign head_o = slot_q[0];
  assign pop    = vld_o && rdy_i;

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        slot_d[i] = slot_d[i+1];
      end
      cnt_d = cnt_d - QCntW'(1);
    end
    if (fire_i && res_i.n != 2'd0) begin
      slot_d[cnt_d[QIdxW-1:0]] = res_i.r0;
      if (res_i.n == 2'd2) begin
        slot_d[QIdxW'(cnt_d[QIdxW-1:0] + QIdxW'(1))] = res_i.r1;
      end
      cnt_d = cnt_d + QCntW'(res_i.n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

@@ sv/touch_spike_reject_filter_unit.sv @@
// ----------------------------------------------------------------------------
// touch_spike_reject_filter_unit
// Input transfer to first result passes the input register, then the queue.
// Throughput: one sample per cycle while the queue has room; results leave at
// one per cycle while m_axis_tready is high, through a 3-entry output queue.
// Reset: held/suspect cleared and invalid, distance limit back to 30.
// ----------------------------------------------------------------------------
module touch_spike_reject_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // in_x[15:0], in_y[31:16], in_pressure[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_x[15:0], out_y[31:16], out_pressure[47:32]
  output logic        m_axis_tlast,  // out_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i     // distance_limit
);
  import tsrf_pkg::*;

  logic      in_vld_q;
  sample_t   in_smp_q;
  logic      fire, room;
  res_t      res;
  out_item_t head;

  assign fire          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || fire;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_smp_q <= sample_t'(s_axis_tdata);
    end
  end

  tsrf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .smp_i      (in_smp_q),
    .res_o      (res)
  );

  tsrf_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .res_i  (res),
    .room_o (room),
    .vld_o  (m_axis_tvalid),
    .rdy_i  (m_axis_tready),
    .head_o (head)
  );

  assign m_axis_tdata = DataW'(head.s);
  assign m_axis_tlast = head.last;

endmodule

@@ sv/tsrf_checker.sv @@
// ----------------------------------------------------------------------------
// tsrf_checker
// Port-level checks on the touch spike reject filter output stream.
// ----------------------------------------------------------------------------
`include "touch_spike_reject_filter_unit_assert.svh"

module tsrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `TSRF_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
  `TSRF_ASSERT_RST(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "output valid during reset")
  `TSRF_ASSERT(a_penup_last, m_axis_tvalid && m_axis_tdata[47:32] == 16'd0 |-> m_axis_tlast, "pen-up result not last")
  `TSRF_ASSERT(a_dup_pair, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast && m_axis_tdata == $past(m_axis_tdata), "second result of a pair differs")

endmodule

bind touch_spike_reject_filter_unit tsrf_checker u_tsrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/touch_spike_reject_filter_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_spike_reject_filter_unit_checker
// Watches the sample, result and limit channels of the spike reject filter.
// Keeps its own copy of the held and suspect samples to predict the emitted
// samples, then compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module touch_spike_reject_filter_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_cnt_o,
  output int          pending_o
);
  import tsrf_pkg::*;

  logic [LimitW-1:0] radius = LimitReset;
  sample_t           held_smp = '0;
  sample_t           suspect_smp = '0;
  bit                held_ok = 1'b0;
  bit                suspect_ok = 1'b0;
  out_item_t         emitted_q[$];
  int                mismatch_cnt = 0;

  // squared distance against squared radius, both exact in 64 bits
  function automatic bit is_far(sample_t a, sample_t anchor, logic [LimitW-1:0] r);
    longint dx;
    longint dy;
    longint lim;
    dx  = longint'(a.x) - longint'(anchor.x);
    dy  = longint'(a.y) - longint'(anchor.y);
    lim = longint'(r) * longint'(r);
    return (dx * dx + dy * dy) > lim;
  endfunction

  task automatic emit(sample_t s, logic last);
    out_item_t it;
    it.s    = s;
    it.last = last;
    emitted_q.push_back(it);
  endtask

  task automatic filter_sample(sample_t smp);
    if (smp.p == '0) begin
      held_smp   = smp;
      held_ok    = 1'b0;
      suspect_ok = 1'b0;
      emit(smp, 1'b1);
    end else if (!held_ok) begin
      held_smp = smp;
      held_ok  = 1'b1;
      emit(smp, 1'b1);
    end else if (is_far(smp, held_smp, radius)) begin
      if (suspect_ok) begin
        // second jump: suspect is promoted, then the input is checked against it
        held_smp    = suspect_smp;
        suspect_smp = smp;
        if (is_far(smp, held_smp, radius)) begin
          emit(held_smp, 1'b1);
        end else begin
          suspect_ok = 1'b0;
          emit(held_smp, 1'b0);
          emit(held_smp, 1'b1);
          held_smp = smp;
        end
      end else begin
        suspect_ok  = 1'b1;
        suspect_smp = smp;
      end
    end else begin
      suspect_ok = 1'b0;
      emit(held_smp, 1'b1);
      held_smp = smp;
    end
  endtask

  task automatic report(string field, longint want_v, longint got_v);
    mismatch_cnt++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  task automatic check_result(sample_t got, logic got_last);
    out_item_t want;
    if (emitted_q.size() == 0) begin
      mismatch_cnt++;
      $display("%0t: result expected none, got x=%0d y=%0d p=%0d last=%0b",
               $time, got.x, got.y, got.p, got_last);
    end else begin
      want = emitted_q.pop_front();
      if (got.x !== want.s.x) report("out_x", want.s.x, got.x);
      if (got.y !== want.s.y) report("out_y", want.s.y, got.y);
      if (got.p !== want.s.p) report("out_pressure", want.s.p, got.p);
      if (got_last !== want.last) report("out_last", want.last, got_last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius      = LimitReset;
      held_smp    = '0;
      suspect_smp = '0;
      held_ok     = 1'b0;
      suspect_ok  = 1'b0;
      emitted_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) radius = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) filter_sample(sample_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) check_result(sample_t'(m_axis_tdata), m_axis_tlast);
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_o      <= emitted_q.size();
  end

endmodule

@@ tb/touch_spike_reject_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_spike_reject_filter_unit_tb
// Drives touch samples into the spike reject filter: a directed pass over
// pen-up, first touch, small moves, single and double jumps and extreme
// coordinates, then random strokes with spikes and noise under several
// distance limits and idle/stall mixes. The checker judges every result.
// ----------------------------------------------------------------------------
module touch_spike_reject_filter_unit_tb;
  import tsrf_pkg::*;

  localparam int QuietLimit  = 4000;
  localparam int DrainPause  = 8;
  localparam int PhaseItems  = 165;
  localparam int BurstCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  int          mismatch_cnt;
  int          pending_cnt;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          burst_req = 1'b0;
  int          burst_left = 0;
  int          quiet = 0;
  logic [15:0] radius = LimitReset;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;

  always #5 clk_i = ~clk_i;

  touch_spike_reject_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  touch_spike_reject_filter_unit_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // result side: random stalls plus a single long hold-off
  always @(posedge clk_i) begin
    if (burst_req) begin
      burst_left = BurstCycles;
      burst_req  = 1'b0;
    end
    if (burst_left != 0) begin
      burst_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(int x, int y, int p);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {16'(p), 16'(y), 16'(x)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [15:0] lim);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    radius = lim;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // strokes of small moves, with pen-ups, lone spikes, relocations and noise
  task automatic random_strokes(int count);
    int          r;
    int          dx;
    int          dy;
    int          stepmax;
    logic [15:0] p;
    stepmax = (radius < 16'd2000) ? int'(radius) + 2 : 2000;
    repeat (count) begin
      r = $urandom_range(99);
      p = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
      if (r < 4) begin
        pos_x = 16'($urandom);
        pos_y = 16'($urandom);
        send(pos_x, pos_y, 16'd0);
      end else if (r < 9) begin
        send(16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 15) begin
        send(pos_x + 16'($urandom), pos_y + 16'($urandom), p);
      end else if (r < 20) begin
        pos_x = pos_x + 16'($urandom);
        pos_y = pos_y + 16'($urandom);
        send(pos_x, pos_y, p);
      end else begin
        dx = int'($urandom_range(2 * stepmax)) - stepmax;
        dy = int'($urandom_range(2 * stepmax)) - stepmax;
        pos_x = pos_x + 16'(dx);
        pos_y = pos_y + 16'(dy);
        send(pos_x, pos_y, p);
      end
    end
  endtask

  initial begin
    logic [15:0] radii [8];
    radii = '{16'd0, 16'hFFFF, 16'd1, 16'd2000, 16'd30, 16'd7, 16'd500, 16'd0};
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, limit at its reset value of 30
    send(100, 100, 500);
    send(110, 105, 600);
    send(1000, 1000, 700);
    send(112, 106, 650);
    send(2000, 2000, 10);
    send(-2000, -2000, 20);
    send(-1990, -1995, 30);
    send(5, 5, 0);
    send(-32768, 32767, 0);
    send(-32768, -32768, 65535);
    send(32767, 32767, 65535);
    send(-32768, -32768, 1);
    send(-32738, -32768, 2);
    send(-32720, -32744, 3);
    send(-32689, -32744, 4);
    send(-32689, -32744, 5);
    send(32767, -32768, 65535);
    send(-32768, 32767, 1);
    send(0, 0, 0);
    send(7, 7, 9);
    send(7, 7, 9);

    for (int ph = 0; ph < 8; ph++) begin
      write_radius((ph == 7) ? 16'($urandom) : radii[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == 4) burst_req = 1'b1;
      random_strokes(PhaseItems);
    end

    settle();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
